// File: rtl/bus_region_map_and_decode_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bus region map and decode unit
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef BUS_REGION_MAP_AND_DECODE_UNIT_ASSERT_SVH
`define BUS_REGION_MAP_AND_DECODE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define BRMD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BRMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BRMD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BRMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: rtl/brmd_pkg.sv
// ---------------------------------------------------------------------------
// brmd_pkg
// Types and constants shared by the bus region map and decode unit.
// ---------------------------------------------------------------------------
package brmd_pkg;

    localparam int DEF_MAX_WINDOWS = 16;
    localparam int DEF_BUS_SPAN    = 65536;

    // action codes
    localparam logic [1:0] ACT_REG   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_OOB     = 3'd1;
    localparam logic [2:0] ST_EXCEEDS = 3'd2;
    localparam logic [2:0] ST_OVERLAP = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [15:0] length;
        logic [7:0]  device_id;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  target_id;
        logic [15:0] offset;
        logic        is_write;
        logic [7:0]  data_out;
    } t_out_item;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

endpackage

// File: rtl/brmd_ram.sv
// ---------------------------------------------------------------------------
// brmd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module brmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bus_region_map_and_decode_unit.sv
// Flow: a read, write or register item is scanned against every slot of
//   the window RAM before its result goes out; a register item that runs past
//   the bus skips the scan. Action code 3 is consumed with no result.
// One item at a time: a new one is taken only in idle, after the last result
//   has moved out; the single RAM read port is scanned one entry per cycle.
// Reset: synchronous, active low; clears all window valid bits and control.
// ---------------------------------------------------------------------------
// bus_region_map_and_decode_unit
// Window table in RAM, scanned entry by entry to decode or register windows.
// ---------------------------------------------------------------------------
`include "bus_region_map_and_decode_unit_assert.svh"

module bus_region_map_and_decode_unit #(
    parameter int MAX_WINDOWS = brmd_pkg::DEF_MAX_WINDOWS,
    parameter int BUS_SPAN    = brmd_pkg::DEF_BUS_SPAN
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  brmd_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output brmd_pkg::t_out_item o_out
);

    import brmd_pkg::*;

    localparam int IW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_WINDOWS - 1);
    localparam logic [16:0]   SPAN     = 17'(BUS_SPAN);

    t_state r_state, n_state;

    logic [MAX_WINDOWS-1:0] r_valid;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_pend, n_pend;
    logic [IW-1:0]          r_pend_idx, n_pend_idx;
    t_in_item               r_item;

    // sticky scan results
    logic          r_found, n_found;
    logic [7:0]    r_tid, n_tid;
    logic [15:0]   r_off, n_off;
    logic          r_ovl, n_ovl;
    logic          r_free_ok, n_free_ok;
    logic [IW-1:0] r_free_idx, n_free_idx;

    t_out_item r_res, n_res;
    logic      r_out_valid, n_out_valid;
    t_out_item r_out, n_out;

    logic             w_accept;
    logic             w_exceeds;
    logic             w_slot_free;
    logic             w_re;
    logic             w_we;
    logic [ENTRY_W-1:0] w_rdata;
    t_entry           w_ent;
    t_entry           w_wr_ent;
    logic             w_ent_v;
    logic [16:0]      w_ent_end;
    logic [16:0]      w_new_end;
    logic             w_hit;
    logic             w_ovl;
    logic             w_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_exceeds   = ({1'b0, i_in.address} + {1'b0, i_in.length}) > SPAN;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // window RAM
    assign w_re = (r_state == S_SCAN);
    assign w_wr_ent = '{start: r_item.address, length: r_item.length, id: r_item.device_id};

    brmd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_WINDOWS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (n_free_idx),
        .i_wdata (w_wr_ent),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    // evaluation of the entry read in the previous cycle
    assign w_ent     = t_entry'(w_rdata);
    assign w_ent_v   = r_pend && r_valid[r_pend_idx];
    assign w_ent_end = {1'b0, w_ent.start} + {1'b0, w_ent.length};
    assign w_new_end = {1'b0, r_item.address} + {1'b0, r_item.length};
    assign w_hit     = w_ent_v && (r_item.address >= w_ent.start)
                       && ({1'b0, r_item.address} < w_ent_end);
    assign w_ovl     = w_ent_v && ((w_ent.start == r_item.address)
                       || ((w_ent.start < r_item.address)
                           && ({1'b0, r_item.address} < w_ent_end))
                       || ((w_ent.start > r_item.address)
                           && (w_new_end > {1'b0, w_ent.start})));
    assign w_free    = r_pend && !r_valid[r_pend_idx];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_in.action != ACT_NONE)) begin
                    if ((i_in.action == ACT_REG) && w_exceeds) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_found     = r_found;
        n_tid       = r_tid;
        n_off       = r_off;
        n_ovl       = r_ovl;
        n_free_ok   = r_free_ok;
        n_free_idx  = r_free_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;

        if (r_pend) begin
            if (w_hit && !r_found) begin
                n_found = 1'b1;
                n_tid   = w_ent.id;
                n_off   = r_item.address - w_ent.start;
            end
            if (w_ovl) begin
                n_ovl = 1'b1;
            end
            if (w_free && !r_free_ok) begin
                n_free_ok  = 1'b1;
                n_free_idx = r_pend_idx;
            end
        end

        case (r_state)
            S_IDLE: begin
                n_idx     = '0;
                n_found   = 1'b0;
                n_ovl     = 1'b0;
                n_free_ok = 1'b0;
                n_res     = '0;
                if (w_accept && (i_in.action == ACT_REG) && w_exceeds) begin
                    n_res.status = ST_EXCEEDS;
                end
            end
            S_SCAN: begin
                n_pend     = 1'b1;
                n_pend_idx = r_idx;
                if (r_idx != LAST_IDX) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_res = '0;
                if (r_item.action == ACT_REG) begin
                    if (n_ovl) begin
                        n_res.status = ST_OVERLAP;
                    end else if (!n_free_ok) begin
                        n_res.status = ST_FULL;
                    end else begin
                        n_res.status = ST_OK;
                        w_we         = 1'b1;
                    end
                end else if (n_found) begin
                    n_res.status    = ST_OK;
                    n_res.target_id = n_tid;
                    n_res.offset    = n_off;
                    if (r_item.action == ACT_WRITE) begin
                        n_res.is_write = 1'b1;
                        n_res.data_out = r_item.write_data;
                    end
                end else begin
                    n_res.status = ST_OOB;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                end
            end
            default: begin
            end
        endcase

        if (r_out_valid && i_out_ready && !((r_state == S_DONE) && w_slot_free)) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (w_we) begin
                r_valid[n_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_in;
        end
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_found    <= n_found;
        r_tid      <= n_tid;
        r_off      <= n_off;
        r_ovl      <= n_ovl;
        r_free_ok  <= n_free_ok;
        r_free_idx <= n_free_idx;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a new window only lands in a free slot
    `BRMD_ASSERT_IMPL(a_write_free_slot, i_clk, i_rst_n, w_we, !r_valid[n_free_idx], "window written over a valid slot")
    // the written slot is valid afterwards
    `BRMD_ASSERT_NEXT(a_slot_marked, i_clk, i_rst_n, w_we, r_valid[$past(n_free_idx)], "written slot not marked valid")
    // a finished result is handed to the output register
    `BRMD_ASSERT_NEXT(a_result_out, i_clk, i_rst_n, (r_state == S_DONE) && w_slot_free, o_out_valid, "result lost on transfer to output")
    // no RAM write while a scan read is in flight
    `BRMD_ASSERT_IMPL(a_no_write_in_scan, i_clk, i_rst_n, w_we, !w_re, "RAM write during scan")

endmodule
